@@ rtl/assert_macros.svh @@
// assertion helpers for the trainer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while reset is low
`define ERNN_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define ERNN_ASSERT_ANY(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/ernn_pkg.sv @@
`timescale 1ns / 1ps

package ernn_pkg;

   localparam int NUM_IN  = 3;
   localparam int NUM_OUT = 3;

   localparam logic [1:0] REQ_LEARN = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd2;

   localparam logic [1:0] CSR_LEARN_RATE = 2'd0;
   localparam logic [1:0] CSR_THRESHOLD  = 2'd1;

   localparam logic [11:0] LEARN_RATE_RST = 12'd819;
   localparam logic [12:0] THRESHOLD_RST  = 13'd1229;

   typedef enum logic [18:0] {
      S_CLR  = 19'h00001,
      S_IDLE = 19'h00002,
      S_FRD  = 19'h00004,
      S_FMUL = 19'h00008,
      S_FACC = 19'h00010,
      S_SIG1 = 19'h00020,
      S_SIG2 = 19'h00040,
      S_EO1  = 19'h00080,
      S_EO2  = 19'h00100,
      S_EO3  = 19'h00200,
      S_HD1  = 19'h00400,
      S_HD2  = 19'h00800,
      S_HD3  = 19'h01000,
      S_LR   = 19'h02000,
      S_LRS  = 19'h04000,
      S_URD  = 19'h08000,
      S_UMUL = 19'h10000,
      S_UWR  = 19'h20000,
      S_DONE = 19'h40000
   } state_type;

   typedef enum logic [1:0] {
      LAYER_HID = 2'd0,
      LAYER_OUT = 2'd1,
      LAYER_ERR = 2'd2
   } layer_type;

   // sigmoid at 0, 0.5 .. 8.0 in Q0.16
   function automatic logic [16:0] sig_point(input logic [4:0] k);
      logic [16:0] v;
      case (k)
         5'd0:    v = 17'd32768;
         5'd1:    v = 17'd40793;
         5'd2:    v = 17'd47910;
         5'd3:    v = 17'd53581;
         5'd4:    v = 17'd57724;
         5'd5:    v = 17'd60564;
         5'd6:    v = 17'd62428;
         5'd7:    v = 17'd63615;
         5'd8:    v = 17'd64357;
         5'd9:    v = 17'd64816;
         5'd10:   v = 17'd65097;
         5'd11:   v = 17'd65269;
         5'd12:   v = 17'd65374;
         5'd13:   v = 17'd65437;
         5'd14:   v = 17'd65476;
         5'd15:   v = 17'd65500;
         default: v = 17'd65514;
      endcase
      return v;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
      logic signed [15:0] r;
      if (v[47:15] != {33{v[47]}}) begin
         r = v[47] ? 16'sh8000 : 16'sh7fff;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v[32] != v[31]) begin
         r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/elman_rnn_online_trainer.sv @@
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// req       in         req_valid / req_ready  req_type, samples, weight index and value
// rsp       out        rsp_valid / rsp_ready  three output levels, predicted unit
// csr       in         csr_valid / csr_ready  csr_index, csr_wdata
//
// one shared 29x17 multiplier with a sequencer; each MAC steps FRD, FMUL, FACC
// a weight write completes at accept
// after reset the weight memory is cleared, one weight at a time (183 by default)
// req_ready stays low while an item runs; a finished result waits in the rsp register
// csr is always ready

`include "assert_macros.svh"

module elman_rnn_online_trainer #(
   parameter int HIDDEN_UNITS  = 10,
   parameter int CONTEXT_UNITS = 10,
   parameter int FRAC_BITS     = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic signed [15:0] req_sample_a,
   input  logic signed [15:0] req_sample_b,
   input  logic signed [15:0] req_sample_c,
   input  logic [7:0]         req_weight_index,
   input  logic signed [15:0] req_weight_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [12:0]        rsp_level_a,
   output logic [12:0]        rsp_level_b,
   output logic [12:0]        rsp_level_c,
   output logic [1:0]         rsp_predicted_unit,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [12:0]        csr_wdata
);

   localparam int H       = HIDDEN_UNITS;
   localparam int C       = CONTEXT_UNITS;
   localparam int F       = FRAC_BITS;
   localparam int NI      = ernn_pkg::NUM_IN;
   localparam int NO      = ernn_pkg::NUM_OUT;
   localparam int IH_SIZE = (NI + 1) * H;
   localparam int CH_SIZE = (C + 1) * H;
   localparam int HO_SIZE = (H + 1) * NO;
   localparam int CH_BASE = IH_SIZE;
   localparam int HO_BASE = IH_SIZE + CH_SIZE;
   localparam int W_TOTAL = IH_SIZE + CH_SIZE + HO_SIZE;
   localparam int AW      = $clog2(W_TOTAL);
   localparam int CNT_W   = $clog2(H + C + NI + 3);
   localparam int HIX_W   = (H > 1) ? $clog2(H) : 1;
   localparam int CIX_W   = (C > 1) ? $clog2(C) : 1;
   localparam int SIG_RND = 1 << (15 - F);
   localparam int SIG_SH  = 16 - F;
   localparam logic signed [15:0] ONE16 = 16'(1 << F);

   ernn_pkg::state_type state_ff, state_in;
   ernn_pkg::layer_type layer_ff, layer_in;
   logic                upd_ff, upd_in;
   logic [CNT_W-1:0]    unit_ff, unit_in, term_ff, term_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic signed [31:0]  acc_ff, acc_in;
   logic signed [45:0]  prod_ff, prod_in;
   logic signed [28:0]  lrerr_ff, lrerr_in;
   logic                learn_ff, learn_in;
   logic                first_ff, first_in;
   logic [11:0]         lr_ff, lr_in;
   logic [12:0]         thr_ff, thr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [12:0]         lvl_a_ff, lvl_b_ff, lvl_c_ff;
   logic [1:0]          pred_ff;

   logic signed [15:0] wmem [W_TOTAL];
   logic signed [15:0] wrd_ff;
   logic signed [15:0] hid_ff  [H];
   logic signed [15:0] ctx_ff  [C];
   logic signed [15:0] errh_ff [H];
   logic signed [15:0] erro_ff [NO];
   logic signed [15:0] outs_ff [NO];
   logic signed [15:0] x_ff    [NI];
   logic signed [15:0] tgt_ff  [NI];
   logic signed [15:0] cur_ff  [NI];

   logic               req_fire, csr_fire;
   logic               mem_we;
   logic [AW-1:0]      mem_addr, seq_addr;
   logic signed [15:0] mem_wdata, upd_w;
   logic               hid_we, outs_we, erro_we, errh_we, ctx_copy, rsp_load, wr_load;
   logic signed [15:0] act, err_sel, sig_res;
   logic               last_term, last_unit;
   logic signed [28:0] mul_a;
   logic signed [16:0] mul_b;
   logic [1:0]         pred_calc;
   logic [HIX_W-1:0]   u_h, t_h;
   logic [CIX_W-1:0]   t_c;
   logic [1:0]         u_o, t_i;

   // sigmoid datapath
   logic signed [31:0] sz;
   logic               sneg, sbig;
   logic [31:0]        st;
   logic [3:0]         sidx;
   logic [16:0]        sdiff, sv;
   logic [17:0]        srnd;
   logic [15:0]        sr;

   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;
   assign req_ready = (state_ff == ernn_pkg::S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_level_a = lvl_a_ff;
   assign rsp_level_b = lvl_b_ff;
   assign rsp_level_c = lvl_c_ff;
   assign rsp_predicted_unit = pred_ff;

   assign u_h = unit_ff[HIX_W-1:0];
   assign t_h = term_ff[HIX_W-1:0];
   assign u_o = unit_ff[1:0];
   assign t_i = term_ff[1:0];
   assign t_c = CIX_W'(term_ff - CNT_W'(NI));

   // weight address and activation for the current term
   always_comb begin
      int u;
      int t;
      int addr_i;
      u = int'(unit_ff);
      t = int'(term_ff);
      if (layer_ff == ernn_pkg::LAYER_ERR) begin
         addr_i = HO_BASE + u * NO + t;
      end else if (layer_ff == ernn_pkg::LAYER_OUT) begin
         addr_i = HO_BASE + t * NO + u;
      end else if (upd_ff || t < NI) begin
         addr_i = t * H + u;
      end else if (t < NI + C) begin
         addr_i = CH_BASE + (t - NI) * H + u;
      end else if (t == NI + C) begin
         addr_i = NI * H + u;
      end else begin
         addr_i = CH_BASE + C * H + u;
      end
      seq_addr = AW'(addr_i);

      if (layer_ff == ernn_pkg::LAYER_ERR) begin
         act = erro_ff[t_i];
      end else if (layer_ff == ernn_pkg::LAYER_OUT) begin
         act = (t < H) ? hid_ff[t_h] : ONE16;
      end else if (t < NI) begin
         act = x_ff[t_i];
      end else if (!upd_ff && t < NI + C) begin
         act = ctx_ff[t_c];
      end else begin
         act = ONE16;
      end

      if (layer_ff == ernn_pkg::LAYER_ERR) begin
         last_term = (term_ff == CNT_W'(NO - 1));
      end else if (layer_ff == ernn_pkg::LAYER_OUT) begin
         last_term = (term_ff == CNT_W'(H));
      end else if (upd_ff) begin
         last_term = (term_ff == CNT_W'(NI));
      end else begin
         last_term = (term_ff == CNT_W'(NI + C + 1));
      end
      last_unit = (layer_ff == ernn_pkg::LAYER_OUT) ? (unit_ff == CNT_W'(NO - 1))
                                                    : (unit_ff == CNT_W'(H - 1));
      err_sel = (layer_ff == ernn_pkg::LAYER_OUT) ? erro_ff[u_o] : errh_ff[u_h];
   end

   // table sigmoid with linear interpolation
   always_comb begin
      sz    = acc_ff >>> F;
      sneg  = acc_ff[31];
      st    = sneg ? 32'(-sz) : 32'(sz);
      sbig  = (st >= 32'(8 << F));
      sidx  = st[F+2 -: 4];
      sdiff = ernn_pkg::sig_point({1'b0, sidx} + 5'd1) - ernn_pkg::sig_point({1'b0, sidx});
      sv    = sbig ? ernn_pkg::sig_point(5'd16)
                   : ernn_pkg::sig_point({1'b0, sidx}) + 17'(prod_ff >>> (F - 1));
      srnd  = {1'b0, sv} + 18'(SIG_RND);
      sr    = 16'(srnd >> SIG_SH);
      sig_res = sneg ? (ONE16 - $signed(sr)) : $signed(sr);
   end

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ernn_pkg::S_FMUL: begin
            mul_a = 29'(act);
            mul_b = 17'(wrd_ff);
         end
         ernn_pkg::S_SIG1: begin
            mul_a = 29'(sdiff);
            mul_b = 17'(st[F-2:0]);
         end
         ernn_pkg::S_EO1: begin
            mul_a = 29'(outs_ff[u_o]);
            mul_b = 17'(ONE16) - 17'(outs_ff[u_o]);
         end
         ernn_pkg::S_EO2: begin
            mul_a = 29'(17'(tgt_ff[u_o]) - 17'(outs_ff[u_o]));
            mul_b = prod_ff[F +: 17];
         end
         ernn_pkg::S_HD1: begin
            mul_a = 29'(hid_ff[u_h]);
            mul_b = 17'(ONE16) - 17'(hid_ff[u_h]);
         end
         ernn_pkg::S_HD2: begin
            mul_a = 29'($signed(acc_ff[15:0]));
            mul_b = prod_ff[F +: 17];
         end
         ernn_pkg::S_LR: begin
            mul_a = 29'(lr_ff);
            mul_b = 17'(err_sel);
         end
         ernn_pkg::S_UMUL: begin
            mul_a = lrerr_ff;
            mul_b = 17'(act);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   assign upd_w = ernn_pkg::sat16(48'(wrd_ff) + 48'(prod_ff >>> (2 * F)));

   always_comb begin
      pred_calc = 2'd0;
      for (int i = 0; i < NO; i++) begin
         if ($unsigned(outs_ff[i]) >= 16'(thr_ff)) begin
            pred_calc = 2'(i);
         end
      end
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      layer_in  = layer_ff;
      upd_in    = upd_ff;
      unit_in   = unit_ff;
      term_in   = term_ff;
      clr_in    = clr_ff;
      acc_in    = acc_ff;
      lrerr_in  = lrerr_ff;
      learn_in  = learn_ff;
      first_in  = first_ff;
      mem_we    = 1'b0;
      mem_addr  = seq_addr;
      mem_wdata = upd_w;
      hid_we    = 1'b0;
      outs_we   = 1'b0;
      erro_we   = 1'b0;
      errh_we   = 1'b0;
      ctx_copy  = 1'b0;
      rsp_load  = 1'b0;
      wr_load   = 1'b0;
      case (state_ff)
         ernn_pkg::S_CLR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(W_TOTAL - 1)) begin
               state_in = ernn_pkg::S_IDLE;
            end
         end
         ernn_pkg::S_IDLE: begin
            mem_addr  = AW'(req_weight_index);
            mem_wdata = req_weight_value;
            if (req_fire) begin
               if (req_type == ernn_pkg::REQ_WRITE) begin
                  mem_we  = ({24'd0, req_weight_index} < 32'(W_TOTAL));
                  wr_load = 1'b1;
               end else begin
                  learn_in = (req_type == ernn_pkg::REQ_LEARN);
                  if (req_type == ernn_pkg::REQ_LEARN) begin
                     first_in = 1'b1;
                  end
                  unit_in  = '0;
                  term_in  = '0;
                  layer_in = ernn_pkg::LAYER_HID;
                  upd_in   = 1'b0;
                  acc_in   = '0;
                  state_in = ernn_pkg::S_FRD;
               end
            end
         end
         ernn_pkg::S_FRD: state_in = ernn_pkg::S_FMUL;
         ernn_pkg::S_FMUL: state_in = ernn_pkg::S_FACC;
         ernn_pkg::S_FACC: begin
            acc_in = ernn_pkg::sat32(33'(acc_ff) + 33'(prod_ff));
            if (last_term) begin
               state_in = (layer_ff == ernn_pkg::LAYER_ERR) ? ernn_pkg::S_HD1
                                                            : ernn_pkg::S_SIG1;
            end else begin
               term_in  = term_ff + CNT_W'(1);
               state_in = ernn_pkg::S_FRD;
            end
         end
         ernn_pkg::S_SIG1: state_in = ernn_pkg::S_SIG2;
         ernn_pkg::S_SIG2: begin
            hid_we  = (layer_ff == ernn_pkg::LAYER_HID);
            outs_we = (layer_ff == ernn_pkg::LAYER_OUT);
            acc_in  = '0;
            term_in = '0;
            if (last_unit) begin
               unit_in = '0;
               if (layer_ff == ernn_pkg::LAYER_HID) begin
                  layer_in = ernn_pkg::LAYER_OUT;
                  state_in = ernn_pkg::S_FRD;
               end else begin
                  ctx_copy = 1'b1;
                  state_in = learn_ff ? ernn_pkg::S_EO1 : ernn_pkg::S_DONE;
               end
            end else begin
               unit_in  = unit_ff + CNT_W'(1);
               state_in = ernn_pkg::S_FRD;
            end
         end
         ernn_pkg::S_EO1: state_in = ernn_pkg::S_EO2;
         ernn_pkg::S_EO2: state_in = ernn_pkg::S_EO3;
         ernn_pkg::S_EO3: begin
            erro_we = 1'b1;
            if (unit_ff == CNT_W'(NO - 1)) begin
               unit_in  = '0;
               term_in  = '0;
               acc_in   = '0;
               layer_in = ernn_pkg::LAYER_ERR;
               state_in = ernn_pkg::S_FRD;
            end else begin
               unit_in  = unit_ff + CNT_W'(1);
               state_in = ernn_pkg::S_EO1;
            end
         end
         ernn_pkg::S_HD1: begin
            acc_in   = 32'(ernn_pkg::sat16(48'(acc_ff >>> F)));
            state_in = ernn_pkg::S_HD2;
         end
         ernn_pkg::S_HD2: state_in = ernn_pkg::S_HD3;
         ernn_pkg::S_HD3: begin
            errh_we = 1'b1;
            acc_in  = '0;
            term_in = '0;
            if (last_unit) begin
               unit_in  = '0;
               layer_in = ernn_pkg::LAYER_OUT;
               upd_in   = 1'b1;
               state_in = ernn_pkg::S_LR;
            end else begin
               unit_in  = unit_ff + CNT_W'(1);
               state_in = ernn_pkg::S_FRD;
            end
         end
         ernn_pkg::S_LR: state_in = ernn_pkg::S_LRS;
         ernn_pkg::S_LRS: begin
            lrerr_in = prod_ff[28:0];
            state_in = ernn_pkg::S_URD;
         end
         ernn_pkg::S_URD: state_in = ernn_pkg::S_UMUL;
         ernn_pkg::S_UMUL: state_in = ernn_pkg::S_UWR;
         ernn_pkg::S_UWR: begin
            mem_we = 1'b1;
            if (last_term) begin
               term_in = '0;
               if (last_unit) begin
                  unit_in = '0;
                  if (layer_ff == ernn_pkg::LAYER_OUT) begin
                     layer_in = ernn_pkg::LAYER_HID;
                     state_in = ernn_pkg::S_LR;
                  end else begin
                     state_in = ernn_pkg::S_DONE;
                  end
               end else begin
                  unit_in  = unit_ff + CNT_W'(1);
                  state_in = ernn_pkg::S_LR;
               end
            end else begin
               term_in  = term_ff + CNT_W'(1);
               state_in = ernn_pkg::S_URD;
            end
         end
         ernn_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ernn_pkg::S_IDLE;
            end
         end
         default: state_in = ernn_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      lr_in  = lr_ff;
      thr_in = thr_ff;
      if (csr_fire) begin
         case (csr_index)
            ernn_pkg::CSR_LEARN_RATE: lr_in  = csr_wdata[11:0];
            ernn_pkg::CSR_THRESHOLD:  thr_in = csr_wdata;
            default: begin
               lr_in  = lr_ff;
               thr_in = thr_ff;
            end
         endcase
      end
      rsp_valid_in = rsp_load || wr_load || (rsp_valid_ff && !rsp_ready);
   end

   // weight memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         wmem[mem_addr] <= mem_wdata;
      end
      wrd_ff <= wmem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ernn_pkg::S_CLR;
         layer_ff     <= ernn_pkg::LAYER_HID;
         upd_ff       <= 1'b0;
         unit_ff      <= '0;
         term_ff      <= '0;
         clr_ff       <= '0;
         learn_ff     <= 1'b0;
         first_ff     <= 1'b0;
         lr_ff        <= ernn_pkg::LEARN_RATE_RST;
         thr_ff       <= ernn_pkg::THRESHOLD_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         layer_ff     <= layer_in;
         upd_ff       <= upd_in;
         unit_ff      <= unit_in;
         term_ff      <= term_in;
         clr_ff       <= clr_in;
         learn_ff     <= learn_in;
         first_ff     <= first_in;
         lr_ff        <= lr_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // network state that reset clears
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < C; c++) begin
            ctx_ff[c] <= '0;
         end
         for (int i = 0; i < NI; i++) begin
            cur_ff[i] <= '0;
         end
      end else begin
         if (ctx_copy) begin
            for (int c = 0; c < C; c++) begin
               ctx_ff[c] <= (c < H) ? hid_ff[(c < H) ? c : 0] : 16'sd0;
            end
         end
         if (req_fire && req_type != ernn_pkg::REQ_WRITE) begin
            cur_ff[0] <= req_sample_a;
            cur_ff[1] <= req_sample_b;
            cur_ff[2] <= req_sample_c;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      lrerr_ff <= lrerr_in;
      if (hid_we) begin
         hid_ff[u_h] <= sig_res;
      end
      if (outs_we) begin
         outs_ff[u_o] <= sig_res;
      end
      if (erro_we) begin
         erro_ff[u_o] <= ernn_pkg::sat16(48'(prod_ff >>> F));
      end
      if (errh_we) begin
         errh_ff[u_h] <= ernn_pkg::sat16(48'(prod_ff >>> F));
      end
      if (req_fire && req_type != ernn_pkg::REQ_WRITE) begin
         // the sample before this one is the learning target
         for (int i = 0; i < NI; i++) begin
            tgt_ff[i] <= cur_ff[i];
         end
         if (req_type == ernn_pkg::REQ_LEARN && !first_ff) begin
            for (int i = 0; i < NI; i++) begin
               x_ff[i] <= '0;
            end
         end else begin
            x_ff[0] <= req_sample_a;
            x_ff[1] <= req_sample_b;
            x_ff[2] <= req_sample_c;
         end
      end
      if (rsp_load) begin
         lvl_a_ff <= outs_ff[0][12:0];
         lvl_b_ff <= outs_ff[1][12:0];
         lvl_c_ff <= outs_ff[2][12:0];
         pred_ff  <= pred_calc;
      end else if (wr_load) begin
         lvl_a_ff <= '0;
         lvl_b_ff <= '0;
         lvl_c_ff <= '0;
         pred_ff  <= '0;
      end
   end

   `ERNN_ASSERT(a_busy_after_item, (req_valid && req_ready && req_type != ernn_pkg::REQ_WRITE) |=> !req_ready, "ready while an item runs")
   `ERNN_ASSERT(a_write_rsp, (req_valid && req_ready && req_type == ernn_pkg::REQ_WRITE) |=> rsp_valid, "weight write gave no result")
   `ERNN_ASSERT_ANY(a_clear_after_reset, reset |=> !req_ready, "ready during weight clear")

endmodule

@@ dv/ernn_output_checker.sv @@
`timescale 1ns / 1ps

module ernn_output_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic signed [15:0] req_sample_a,
   input  logic signed [15:0] req_sample_b,
   input  logic signed [15:0] req_sample_c,
   input  logic [7:0]         req_weight_index,
   input  logic signed [15:0] req_weight_value,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [12:0]        rsp_level_a,
   input  logic [12:0]        rsp_level_b,
   input  logic [12:0]        rsp_level_c,
   input  logic [1:0]         rsp_predicted_unit,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [12:0]        csr_wdata,
   output int                 fail_count,
   output int                 pending,
   output int                 checked
);

   localparam int NI = ernn_pkg::NUM_IN;
   localparam int NO = ernn_pkg::NUM_OUT;
   localparam int NH = 10;
   localparam int NC = 10;
   localparam int FB = 12;
   localparam longint UNIT = 1 << FB;
   localparam int IH_N = (NI + 1) * NH;
   localparam int CH_N = (NC + 1) * NH;
   localparam int HO_N = (NH + 1) * NO;
   localparam int SIG_PTS [17] = '{32768, 40793, 47910, 53581, 57724, 60564, 62428, 63615,
      64357, 64816, 65097, 65269, 65374, 65437, 65476, 65500, 65514};

   typedef struct packed {
      logic [12:0] lvl_a;
      logic [12:0] lvl_b;
      logic [12:0] lvl_c;
      logic [1:0]  unit;
   } levels_type;

   levels_type expected_levels [$];

   logic [11:0]        rate;
   logic [12:0]        thresh;
   logic signed [15:0] w_ih [IH_N];
   logic signed [15:0] w_ch [CH_N];
   logic signed [15:0] w_ho [HO_N];
   logic signed [15:0] hid [NH];
   logic signed [15:0] ctx [NC];
   logic signed [15:0] cur [NI];
   logic signed [15:0] prev [NI];
   logic               learned;

   function automatic longint clip32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic signed [15:0] clip16(input longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   // table sigmoid with linear interpolation, mirrored for negative inputs
   function automatic logic signed [15:0] squash(input longint acc);
      longint z, t, v, r;
      int k;
      z = acc >>> FB;
      t = (z < 0) ? -z : z;
      if (t >= (longint'(8) << FB)) begin
         v = SIG_PTS[16];
      end else begin
         k = int'(t >>> (FB - 1));
         v = SIG_PTS[k] + (((SIG_PTS[k+1] - SIG_PTS[k]) * (t & ((1 << (FB - 1)) - 1)))
             >>> (FB - 1));
      end
      r = (v + (1 << (15 - FB))) >>> (16 - FB);
      return (z < 0) ? 16'(UNIT - r) : 16'(r);
   endfunction

   function automatic longint slope(input longint a);
      return (a * (UNIT - a)) >>> FB;
   endfunction

   function automatic void run_forward(input logic signed [15:0] x [NI],
                                       output logic signed [15:0] y [NO]);
      longint acc;
      for (int h = 0; h < NH; h++) begin
         acc = 0;
         for (int i = 0; i < NI; i++)
            acc = clip32(acc + longint'(x[i]) * longint'(w_ih[i*NH+h]));
         for (int i = 0; i < NC; i++)
            acc = clip32(acc + longint'(ctx[i]) * longint'(w_ch[i*NH+h]));
         acc = clip32(acc + longint'(w_ih[NI*NH+h]) * UNIT);
         acc = clip32(acc + longint'(w_ch[NC*NH+h]) * UNIT);
         hid[h] = squash(acc);
      end
      for (int o = 0; o < NO; o++) begin
         acc = 0;
         for (int h = 0; h < NH; h++)
            acc = clip32(acc + longint'(hid[h]) * longint'(w_ho[h*NO+o]));
         acc = clip32(acc + longint'(w_ho[NH*NO+o]) * UNIT);
         y[o] = squash(acc);
      end
      for (int i = 0; i < NC; i++)
         ctx[i] = (i < NH) ? hid[i] : 16'sd0;
   endfunction

   function automatic void run_backprop(input logic signed [15:0] x [NI],
                                        input logic signed [15:0] tgt [NI],
                                        input logic signed [15:0] y [NO]);
      logic signed [15:0] eo [NO];
      logic signed [15:0] eh [NH];
      longint acc, lr;
      lr = longint'(rate);
      for (int o = 0; o < NO; o++)
         eo[o] = clip16(((longint'(tgt[o]) - longint'(y[o])) * slope(longint'(y[o]))) >>> FB);
      for (int h = 0; h < NH; h++) begin
         acc = 0;
         for (int o = 0; o < NO; o++)
            acc = clip32(acc + longint'(eo[o]) * longint'(w_ho[h*NO+o]));
         acc = longint'(clip16(acc >>> FB));
         eh[h] = clip16((acc * slope(longint'(hid[h]))) >>> FB);
      end
      for (int o = 0; o < NO; o++) begin
         for (int h = 0; h < NH; h++)
            w_ho[h*NO+o] = clip16(longint'(w_ho[h*NO+o])
               + ((lr * longint'(eo[o]) * longint'(hid[h])) >>> (2 * FB)));
         w_ho[NH*NO+o] = clip16(longint'(w_ho[NH*NO+o])
            + ((lr * longint'(eo[o])) >>> FB));
      end
      for (int h = 0; h < NH; h++) begin
         for (int i = 0; i < NI; i++)
            w_ih[i*NH+h] = clip16(longint'(w_ih[i*NH+h])
               + ((lr * longint'(eh[h]) * longint'(x[i])) >>> (2 * FB)));
         w_ih[NI*NH+h] = clip16(longint'(w_ih[NI*NH+h])
            + ((lr * longint'(eh[h])) >>> FB));
      end
   endfunction

   function automatic levels_type net_step();
      logic signed [15:0] x [NI];
      logic signed [15:0] y [NO];
      levels_type r;
      r = '0;
      if (req_type == ernn_pkg::REQ_WRITE) begin
         if (req_weight_index < IH_N)
            w_ih[req_weight_index] = req_weight_value;
         else if (req_weight_index < IH_N + CH_N)
            w_ch[req_weight_index - IH_N] = req_weight_value;
         else if (req_weight_index < IH_N + CH_N + HO_N)
            w_ho[req_weight_index - IH_N - CH_N] = req_weight_value;
         return r;
      end
      prev = cur;
      cur[0] = req_sample_a;
      cur[1] = req_sample_b;
      cur[2] = req_sample_c;
      if (req_type == ernn_pkg::REQ_LEARN) begin
         for (int i = 0; i < NI; i++)
            x[i] = learned ? cur[i] : 16'sd0;
         run_forward(x, y);
         learned = 1'b1;
         run_backprop(x, prev, y);
      end else begin
         run_forward(cur, y);
      end
      r.lvl_a = y[0][12:0];
      r.lvl_b = y[1][12:0];
      r.lvl_c = y[2][12:0];
      for (int o = 0; o < NO; o++)
         if ({3'b0, y[o][12:0]} >= {3'b0, thresh}) r.unit = 2'(o);
      return r;
   endfunction

   // negedge sampling sees exactly what the next rising edge will transfer
   always @(negedge clock) begin
      levels_type e;
      if (reset) begin
         rate = ernn_pkg::LEARN_RATE_RST;
         thresh = ernn_pkg::THRESHOLD_RST;
         foreach (w_ih[i]) w_ih[i] = '0;
         foreach (w_ch[i]) w_ch[i] = '0;
         foreach (w_ho[i]) w_ho[i] = '0;
         foreach (hid[i]) hid[i] = '0;
         foreach (ctx[i]) ctx[i] = '0;
         foreach (cur[i]) begin
            cur[i] = '0;
            prev[i] = '0;
         end
         learned = 1'b0;
         expected_levels.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == ernn_pkg::CSR_LEARN_RATE) rate = csr_wdata[11:0];
            else if (csr_index == ernn_pkg::CSR_THRESHOLD) thresh = csr_wdata;
         end
         if (req_valid && req_ready)
            expected_levels.push_back(net_step());
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (expected_levels.size() == 0) begin
               $error("result transfer with nothing expected");
               fail_count++;
            end else begin
               e = expected_levels.pop_front();
               if (rsp_level_a !== e.lvl_a) begin
                  $error("level_a expected %0d got %0d", e.lvl_a, rsp_level_a);
                  fail_count++;
               end
               if (rsp_level_b !== e.lvl_b) begin
                  $error("level_b expected %0d got %0d", e.lvl_b, rsp_level_b);
                  fail_count++;
               end
               if (rsp_level_c !== e.lvl_c) begin
                  $error("level_c expected %0d got %0d", e.lvl_c, rsp_level_c);
                  fail_count++;
               end
               if (rsp_predicted_unit !== e.unit) begin
                  $error("predicted_unit expected %0d got %0d", e.unit, rsp_predicted_unit);
                  fail_count++;
               end
            end
         end
      end
      pending = expected_levels.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
      checked = 0;
   end

endmodule

@@ dv/elman_rnn_online_trainer_tb.sv @@
`timescale 1ns / 1ps

module elman_rnn_online_trainer_tb;

   localparam int LIMIT = 8_000_000;
   localparam logic [1:0] REQ_PREDICT  = 2'd1;
   localparam logic [1:0] REQ_ALIAS    = 2'd3;
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_type;
   logic signed [15:0] req_sample_a;
   logic signed [15:0] req_sample_b;
   logic signed [15:0] req_sample_c;
   logic [7:0]         req_weight_index;
   logic signed [15:0] req_weight_value;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [12:0]        rsp_level_a;
   logic [12:0]        rsp_level_b;
   logic [12:0]        rsp_level_c;
   logic [1:0]         rsp_predicted_unit;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [12:0]        csr_wdata;
   int                 fail_count;
   int                 pending;
   int                 checked;
   int                 cycles;
   int                 sent;
   int                 holdoff_left;
   logic               calm;

   elman_rnn_online_trainer i_dut (.*);

   ernn_output_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // result side: random stalls, two long hold-offs while the sender keeps offering
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_ready <= 1'b0;
      end else if (cycles == 30000 || cycles == 500000) begin
         holdoff_left <= 3000;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 33);
      end
   end

   task automatic send(input logic [1:0] kind, input logic signed [15:0] a,
                       input logic signed [15:0] b, input logic signed [15:0] c,
                       input logic [7:0] idx, input logic signed [15:0] val);
      req_valid <= 1'b1;
      req_type <= kind;
      req_sample_a <= a;
      req_sample_b <= b;
      req_sample_c <= c;
      req_weight_index <= idx;
      req_weight_value <= val;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      sent++;
      if (!calm && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [12:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // sender pause: every expected result has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick_sample();
      if ($urandom_range(9) == 0) return 16'($urandom);
      return 16'($signed($urandom_range(16383)) - 8192);
   endfunction

   task automatic random_item();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10)
         send(ernn_pkg::REQ_WRITE, pick_sample(), pick_sample(), pick_sample(),
              ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(182)),
              ($urandom_range(4) == 0) ? 16'($urandom)
                                       : 16'($signed($urandom_range(16383)) - 8192));
      else if (roll < 60)
         send(ernn_pkg::REQ_LEARN, pick_sample(), pick_sample(), pick_sample(),
              8'($urandom), 16'($urandom));
      else if (roll < 94)
         send(REQ_PREDICT, pick_sample(), pick_sample(), pick_sample(),
              8'($urandom), 16'($urandom));
      else
         send(REQ_ALIAS, pick_sample(), pick_sample(), pick_sample(),
              8'($urandom), 16'($urandom));
   endtask

   initial begin
      logic [11:0] rates [6];
      logic [12:0] levels [6];
      cycles = 0;
      sent = 0;
      holdoff_left = 0;
      calm = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = ernn_pkg::REQ_LEARN;
      req_sample_a = '0;
      req_sample_b = '0;
      req_sample_c = '0;
      req_weight_index = '0;
      req_weight_value = '0;
      csr_valid = 1'b0;
      csr_index = ernn_pkg::CSR_LEARN_RATE;
      csr_wdata = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // first learn sees zero inputs, then extremes of samples and weights
      send(ernn_pkg::REQ_LEARN, 16'sh7fff, 16'sh8000, 16'sh7fff, 8'd0, 16'sd0);
      send(ernn_pkg::REQ_LEARN, 16'sh8000, 16'sh7fff, 16'sh8000, 8'd0, 16'sd0);
      send(ernn_pkg::REQ_WRITE, 16'sd0, 16'sd0, 16'sd0, 8'd0, 16'sh7fff);
      send(ernn_pkg::REQ_WRITE, 16'sd0, 16'sd0, 16'sd0, 8'd39, 16'sh8000);
      send(ernn_pkg::REQ_WRITE, 16'sd0, 16'sd0, 16'sd0, 8'd40, 16'sd4096);
      send(ernn_pkg::REQ_WRITE, 16'sd0, 16'sd0, 16'sd0, 8'd149, -16'sd4096);
      send(ernn_pkg::REQ_WRITE, 16'sd0, 16'sd0, 16'sd0, 8'd150, 16'sh7fff);
      send(ernn_pkg::REQ_WRITE, 16'sd0, 16'sd0, 16'sd0, 8'd182, 16'sh8000);
      // out of range weight index is dropped
      send(ernn_pkg::REQ_WRITE, 16'sd0, 16'sd0, 16'sd0, 8'd183, 16'sh7fff);
      send(ernn_pkg::REQ_WRITE, 16'sd0, 16'sd0, 16'sd0, 8'd255, 16'sh7fff);
      send(REQ_PREDICT, 16'sh7fff, 16'sh7fff, 16'sh7fff, 8'hff, 16'shffff);
      send(REQ_ALIAS, 16'sh8000, 16'sh8000, 16'sh8000, 8'hff, 16'shffff);
      send(ernn_pkg::REQ_LEARN, 16'sd4096, -16'sd4096, 16'sd0, 8'd0, 16'sd0);
      send(ernn_pkg::REQ_LEARN, 16'sd0, 16'sd0, 16'sd0, 8'd0, 16'sd0);
      send(REQ_PREDICT, 16'sd0, 16'sd0, 16'sd0, 8'd0, 16'sd0);
      send(ernn_pkg::REQ_WRITE, 16'sd0, 16'sd0, 16'sd0, 8'd170, 16'sh7fff);
      send(REQ_PREDICT, 16'sd100, -16'sd100, 16'sd1, 8'd0, 16'sd0);
      send(ernn_pkg::REQ_LEARN, 16'shffff, 16'sd1, -16'sd2, 8'd0, 16'sd0);
      drain();

      rates  = '{12'd4095, 12'd0, 12'd2048, 12'd0, 12'd0, 12'd819};
      levels = '{13'd0, 13'd4096, 13'd8191, 13'd0, 13'd0, 13'd1229};
      for (int p = 0; p < 6; p++) begin
         if (p == 3) begin
            rates[p] = 12'($urandom);
            levels[p] = 13'($urandom_range(4096));
         end
         if (p == 4) begin
            rates[p] = 12'($urandom);
            levels[p] = 13'($urandom);
            write_reg(CSR_UNMAPPED, 13'($urandom));
         end
         write_reg(ernn_pkg::CSR_LEARN_RATE, 13'(rates[p]));
         write_reg(ernn_pkg::CSR_THRESHOLD, levels[p]);
         calm = (p == 2);
         for (int n = 0; n < 240; n++) random_item();
         drain();
      end
      calm = 1'b0;

      repeat (200) @(posedge clock);
      $display("run covered %0d items and %0d checked results", sent, checked);
      $display("six register settings incl. extremes, weight writes, learn and predict");
      if (fail_count == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ernn_pkg.sv
rtl/elman_rnn_online_trainer.sv
dv/ernn_output_checker.sv
dv/elman_rnn_online_trainer_tb.sv
